FILE: hdl/tlbos_pkg.sv
`default_nettype none
package tlbos_pkg;

  localparam int LOW_BITS  = 8;
  localparam int HIGH_BITS = 8;
  localparam int KEY_BITS  = LOW_BITS + HIGH_BITS;
  localparam int ROW_W     = 1 << LOW_BITS;
  localparam int ROWS      = 1 << HIGH_BITS;
  localparam int CNT_W     = KEY_BITS + 1;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;

  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [ROWS-1:0]      sum_t;
  typedef logic [LOW_BITS-1:0]  low_t;
  typedef logic [HIGH_BITS-1:0] high_t;

  typedef struct packed {
    logic found;
    low_t idx;
  } low_hit_t;

  typedef struct packed {
    logic  found;
    high_t idx;
  } high_hit_t;

  function automatic low_hit_t row_first(input row_t v);
    low_hit_t r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = LOW_BITS'(i);
      end
    end
    return r;
  endfunction

  function automatic low_hit_t row_last(input row_t v);
    low_hit_t r;
    r = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = LOW_BITS'(i);
      end
    end
    return r;
  endfunction

  function automatic high_hit_t sum_first(input sum_t v);
    high_hit_t r;
    r = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = HIGH_BITS'(i);
      end
    end
    return r;
  endfunction

  function automatic high_hit_t sum_last(input sum_t v);
    high_hit_t r;
    r = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = HIGH_BITS'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/tlbos_if.sv
`default_nettype none
interface tlbos_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] key;
  modport source (output valid, kind, key, input ready);
  modport sink (input valid, kind, key, output ready);
endinterface

interface tlbos_rsp_if;
  logic        valid;
  logic        ready;
  logic        was_present;
  logic        successor_valid;
  logic [15:0] successor;
  logic        predecessor_valid;
  logic [15:0] predecessor;
  logic        set_nonempty;
  logic [15:0] minimum;
  logic [15:0] maximum;
  logic [16:0] element_count;
  modport source (output valid, was_present, successor_valid, successor, predecessor_valid,
                  predecessor, set_nonempty, minimum, maximum, element_count, input ready);
  modport sink (input valid, was_present, successor_valid, successor, predecessor_valid,
                predecessor, set_nonempty, minimum, maximum, element_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/tlbos_ram.sv
`default_nettype none
module tlbos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/two_level_bitmap_ordered_set_top.sv
`default_nettype none
// Each accepted request runs through the key row read, update, search, then reads of the
// successor, predecessor, minimum and maximum rows before its response is registered.
// A new request is taken only when idle, after the previous response is registered.
// Reset (rst, synchronous) empties the set at once: per-row valid flops mask
// unwritten RAM rows, and the summary and count registers clear.
module two_level_bitmap_ordered_set_top (
  input wire logic   clk,
  input wire logic   rst,
  tlbos_req_if.sink  req,
  tlbos_rsp_if.source rsp
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_KEY  = 9'b000000010,
    S_SRCH = 9'b000000100,
    S_RD1  = 9'b000001000,
    S_RD2  = 9'b000010000,
    S_RD3  = 9'b000100000,
    S_RD4  = 9'b001000000,
    S_RD5  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [1:0]                   kind;
  tlbos_pkg::high_t             key_h;
  tlbos_pkg::low_t              key_l;
  tlbos_pkg::row_t              krow;
  tlbos_pkg::sum_t              summary;
  tlbos_pkg::sum_t              row_valid;
  logic [tlbos_pkg::CNT_W-1:0]  count;
  logic                         present;
  tlbos_pkg::low_hit_t          in_s, in_p;
  tlbos_pkg::high_hit_t         nh, ph, minc, maxc;
  logic                         sv, pv;
  logic [tlbos_pkg::KEY_BITS-1:0] succ, pred, mn, mx;
  logic                         valid_q;

  logic [tlbos_pkg::KEY_BITS-1:0] req_key;
  tlbos_pkg::high_t             raddr;
  tlbos_pkg::row_t              rdata, rowd, newrow, kbit;
  logic                         we, hit;
  tlbos_pkg::low_hit_t          rf, rl;

  assign req_key = req.key[tlbos_pkg::KEY_BITS-1:0];
  assign req.ready = (state == S_IDLE);

  assign rowd   = rdata & {tlbos_pkg::ROW_W{valid_q}};
  assign hit    = rowd[key_l];
  assign kbit   = tlbos_pkg::ROW_W'(1) << key_l;
  assign newrow = (kind == tlbos_pkg::KIND_INSERT) ? (rowd | kbit) : (rowd & ~kbit);
  assign we     = (state == S_KEY) &&
                  (((kind == tlbos_pkg::KIND_INSERT) && !hit) ||
                   ((kind == tlbos_pkg::KIND_DELETE) && hit));
  assign rf     = tlbos_pkg::row_first(rowd);
  assign rl     = tlbos_pkg::row_last(rowd);

  always_comb begin
    unique case (state)
      S_IDLE:  raddr = req_key[tlbos_pkg::KEY_BITS-1:tlbos_pkg::LOW_BITS];
      S_RD1:   raddr = nh.idx;
      S_RD2:   raddr = ph.idx;
      S_RD3:   raddr = minc.idx;
      S_RD4:   raddr = maxc.idx;
      default: raddr = key_h;
    endcase
  end

  tlbos_ram #(
    .WIDTH(tlbos_pkg::ROW_W),
    .DEPTH(tlbos_pkg::ROWS)
  ) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(key_h),
    .wdata(newrow),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_KEY;
      S_KEY:   state_next = S_SRCH;
      S_SRCH:  state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_RD3;
      S_RD3:   state_next = S_RD4;
      S_RD4:   state_next = S_RD5;
      S_RD5:   state_next = S_OUT;
      S_OUT:   if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      summary   <= '0;
      row_valid <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_KEY) begin
        // A write lands here, so later reads of this row see the new bits.
        if (we) begin
          row_valid[key_h] <= 1'b1;
          if (kind == tlbos_pkg::KIND_INSERT) begin
            summary[key_h] <= 1'b1;
            count          <= count + 1'b1;
          end else begin
            summary[key_h] <= |newrow;
            count          <= count - 1'b1;
          end
        end
      end
      if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= row_valid[raddr];
    unique case (state)
      S_IDLE: begin
        kind  <= req.kind;
        key_h <= req_key[tlbos_pkg::KEY_BITS-1:tlbos_pkg::LOW_BITS];
        key_l <= req_key[tlbos_pkg::LOW_BITS-1:0];
      end
      S_KEY: begin
        present <= hit;
        krow    <= we ? newrow : rowd;
      end
      S_SRCH: begin
        in_s <= tlbos_pkg::row_first(krow & ((~tlbos_pkg::row_t'(0) << key_l) << 1));
        in_p <= tlbos_pkg::row_last(krow & ~(~tlbos_pkg::row_t'(0) << key_l));
        nh   <= tlbos_pkg::sum_first(summary & ((~tlbos_pkg::sum_t'(0) << key_h) << 1));
        ph   <= tlbos_pkg::sum_last(summary & ~(~tlbos_pkg::sum_t'(0) << key_h));
        minc <= tlbos_pkg::sum_first(summary);
        maxc <= tlbos_pkg::sum_last(summary);
      end
      S_RD2: begin
        if (in_s.found) begin
          sv   <= 1'b1;
          succ <= {key_h, in_s.idx};
        end else if (nh.found) begin
          sv   <= 1'b1;
          succ <= {nh.idx, rf.idx};
        end else begin
          sv   <= 1'b0;
          succ <= '0;
        end
      end
      S_RD3: begin
        if (in_p.found) begin
          pv   <= 1'b1;
          pred <= {key_h, in_p.idx};
        end else if (ph.found) begin
          pv   <= 1'b1;
          pred <= {ph.idx, rl.idx};
        end else begin
          pv   <= 1'b0;
          pred <= '0;
        end
      end
      S_RD4: mn <= minc.found ? {minc.idx, rf.idx} : '0;
      S_RD5: mx <= maxc.found ? {maxc.idx, rl.idx} : '0;
      default: ;
    endcase
    if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
      rsp.was_present       <= present;
      rsp.successor_valid   <= sv;
      rsp.successor         <= 16'(succ);
      rsp.predecessor_valid <= pv;
      rsp.predecessor       <= 16'(pred);
      rsp.set_nonempty      <= minc.found;
      rsp.minimum           <= 16'(mn);
      rsp.maximum           <= 16'(mx);
      rsp.element_count     <= 17'(count);
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/two_level_bitmap_ordered_set_top_tb.sv
module two_level_bitmap_ordered_set_top_tb;

  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_ODD   = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_OPS = 1830;

  typedef struct packed {
    logic        was_present;
    logic        successor_valid;
    logic [15:0] successor;
    logic        predecessor_valid;
    logic [15:0] predecessor;
    logic        set_nonempty;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [16:0] element_count;
  } answer_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key;
    logic        fixed;
    answer_t     ans;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tlbos_req_if req ();
  tlbos_rsp_if rsp ();

  two_level_bitmap_ordered_set_top dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: one bit per key, plus count
  logic [65535:0] key_map;
  int unsigned    key_total;
  answer_t        pending_answers[$];
  int             mismatch_count = 0;
  int             accepted_requests = 0;
  int             checked_answers = 0;
  int             idle_cycles = 0;
  bit             stim_done = 1'b0;
  logic [15:0]    hot_keys[$];

  function automatic answer_t apply_op(logic [1:0] kind, logic [15:0] key);
    answer_t a;
    int i;
    a = '0;
    a.was_present = key_map[key];
    if (kind == tlbos_pkg::KIND_INSERT && !key_map[key]) begin
      key_map[key] = 1'b1;
      key_total++;
    end else if (kind == tlbos_pkg::KIND_DELETE && key_map[key]) begin
      key_map[key] = 1'b0;
      key_total--;
    end
    for (i = int'(key) + 1; i < 65536; i++)
      if (key_map[i]) begin
        a.successor_valid = 1'b1;
        a.successor = 16'(i);
        break;
      end
    for (i = int'(key) - 1; i >= 0; i--)
      if (key_map[i]) begin
        a.predecessor_valid = 1'b1;
        a.predecessor = 16'(i);
        break;
      end
    for (i = 0; i < 65536; i++)
      if (key_map[i]) begin
        a.set_nonempty = 1'b1;
        a.minimum = 16'(i);
        break;
      end
    for (i = 65535; i >= 0; i--)
      if (key_map[i]) begin
        a.maximum = 16'(i);
        break;
      end
    a.element_count = 17'(key_total);
    return a;
  endfunction

  // directed rows; fixed answers only where obvious
  stim_row_t directed[$];

  function automatic stim_row_t row(logic [1:0] k, logic [15:0] key, logic fixed, answer_t a);
    stim_row_t r;
    r.kind = k;
    r.key = key;
    r.fixed = fixed;
    r.ans = a;
    return r;
  endfunction

  initial begin
    directed.push_back(row(KIND_QUERY, 16'h0000, 1'b1, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'hFFFF, 1'b1, '0));
    directed.push_back(row(tlbos_pkg::KIND_INSERT, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b1, 16'h0, 16'h0, 17'd1}));
    directed.push_back(row(tlbos_pkg::KIND_INSERT, 16'hFFFF, 1'b1,
                           '{1'b0, 1'b0, 16'h0, 1'b1, 16'h0, 1'b1, 16'h0, 16'hFFFF, 17'd2}));
    directed.push_back(row(tlbos_pkg::KIND_INSERT, 16'hFFFF, 1'b1,
                           '{1'b1, 1'b0, 16'h0, 1'b1, 16'h0, 1'b1, 16'h0, 16'hFFFF, 17'd2}));
    directed.push_back(row(KIND_QUERY, 16'h8000, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_INSERT, 16'h00FF, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_INSERT, 16'h0100, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_INSERT, 16'h5A5A, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_INSERT, 16'hA5A5, 1'b0, '0));
    directed.push_back(row(KIND_ODD, 16'h5A5A, 1'b0, '0));
    directed.push_back(row(KIND_ODD, 16'h5A5B, 1'b0, '0));
    directed.push_back(row(KIND_QUERY, 16'h00FF, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'h0100, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'h0100, 1'b0, '0));
    directed.push_back(row(KIND_QUERY, 16'h0101, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'h0000, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'hFFFF, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'h00FF, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'h5A5A, 1'b0, '0));
    directed.push_back(row(tlbos_pkg::KIND_DELETE, 16'hA5A5, 1'b0, '0));
    directed.push_back(row(KIND_QUERY, 16'hFFFF, 1'b1, '0));
  end

  task automatic send_request(logic [1:0] kind, logic [15:0] key, logic fixed, answer_t a);
    answer_t p;
    int gap;
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.key   <= key;
    do @(posedge clk); while (!req.ready);
    p = apply_op(kind, key);
    if (fixed && p != a) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("table row disagrees with predictor: kind %0d key %h expected %p actual %p",
                 kind, key, a, p);
    end
    pending_answers.push_back(fixed ? a : p);
    accepted_requests++;
    @(negedge clk);
    // burst sender: drop valid only between bursts
    if ($urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] pick_key();
    logic [15:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = hot_keys.size() ? hot_keys[$urandom_range(0, hot_keys.size() - 1)]
                                   : 16'($urandom);
      3: k = {8'($urandom_range(0, 3)), 8'($urandom)};
      4: k = {8'($urandom_range(252, 255)), 8'($urandom)};
      5: k = {8'($urandom), ($urandom_range(0, 1) ? 8'h00 : 8'hFF)};
      default: k = 16'($urandom);
    endcase
    return k;
  endfunction

  initial begin
    logic [1:0]  k;
    logic [15:0] key;
    int n;
    key_map = '0;
    key_total = 0;
    req.valid = 1'b0;
    req.kind = KIND_QUERY;
    req.key = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (n = 0; n < directed.size(); n++)
      send_request(directed[n].kind, directed[n].key, directed[n].fixed, directed[n].ans);
    for (n = 0; n < RANDOM_OPS; n++) begin
      key = pick_key();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = tlbos_pkg::KIND_INSERT;
        4, 5, 6: k = tlbos_pkg::KIND_DELETE;
        7, 8: k = KIND_QUERY;
        default: k = KIND_ODD;
      endcase
      if (k == tlbos_pkg::KIND_INSERT && hot_keys.size() < 64) hot_keys.push_back(key);
      // phase toward a drained set near the middle, then refill
      if (n > 800 && n < 1000) k = tlbos_pkg::KIND_DELETE;
      send_request(k, key, 1'b0, '0);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern
  logic [7:0] stall_pat = 8'b1011_0111;
  int         stall_step = 0;
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall_step++;
      if ((stall_step / 300) % 3 == 2) rsp.ready <= 1'b1;
      else if ($urandom_range(0, 15) == 0) rsp.ready <= 1'b0;
      else rsp.ready <= stall_pat[stall_step % 8];
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.was_present, rsp.successor_valid, rsp.successor, rsp.predecessor_valid,
              rsp.predecessor, rsp.set_nonempty, rsp.minimum, rsp.maximum, rsp.element_count};
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("response with nothing outstanding: %p", got);
      end else begin
        want = pending_answers.pop_front();
        checked_answers++;
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("response %0d mismatch: expected %p actual %p",
                     checked_answers, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done && pending_answers.size() == 0);
    repeat (30) @(posedge clk);
    $display("ran %0d requests (inserts, deletes, queries, kind 3), checked %0d responses",
             accepted_requests, checked_answers);
    $display("final set size %0d, %0d mismatches", key_total, mismatch_count);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("two_level_bitmap_ordered_set_top_tb: clean");
    else
      $display("two_level_bitmap_ordered_set_top_tb: errors");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("two_level_bitmap_ordered_set_top_tb: errors");
    $finish;
  end
endmodule
